// File: rtl/core/timed_blink_pattern_generator_core_macros.svh
// Assertion macros for the blink pattern generator core.
`ifndef TIMED_BLINK_PATTERN_GENERATOR_CORE_MACROS_SVH
`define TIMED_BLINK_PATTERN_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTH
// Checked out of reset only.
`define TBPG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge.
`define TBPG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBPG_ASSERT(name, prop, msg)
`define TBPG_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: rtl/core/tbpg_pkg.sv
package tbpg_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_CANCEL = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        PAT_KEYPOINT = 3'd0,
        PAT_STOP     = 3'd1,
        PAT_COMPLETE = 3'd2,
        PAT_ERROR    = 3'd3,
        PAT_AIM_OK   = 3'd4,
        PAT_SHORT    = 3'd5
    } pattern_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [2:0]  pattern;
    } req_t;

    typedef struct packed {
        logic signal_on;
        logic active;
    } rsp_t;

    localparam logic [15:0] KEYPOINT_RESET_MS = 16'd100;

    localparam logic [31:0] STOP_MS           = 32'd1000;
    localparam logic [31:0] SHORT_MS          = 32'd5;

    localparam logic [31:0] COMPLETE_TOTAL_MS = 32'd3000;
    localparam logic [7:0]  COMPLETE_ON_MS    = 8'd250;
    localparam logic [7:0]  COMPLETE_OFF_MS   = 8'd250;

    localparam logic [31:0] ERROR_TOTAL_MS    = 32'd600;
    localparam logic [7:0]  ERROR_ON_MS       = 8'd100;
    localparam logic [7:0]  ERROR_OFF_MS      = 8'd100;

    localparam logic [31:0] AIM_OK_TOTAL_MS   = 32'd220;
    localparam logic [7:0]  AIM_OK_ON_MS      = 8'd10;
    localparam logic [7:0]  AIM_OK_OFF_MS     = 8'd100;

endpackage

// File: rtl/core/timed_blink_pattern_generator_core.sv
// A request accepted into the input register moves on into the response register as soon
// as that register is empty or being drained.
// Throughput: one request per cycle while the response register is empty or being drained;
// the pattern state updates as a request moves from the input register into the response register.
// Reset (rst_n low, asynchronous): both stages empty, no pattern running, output off,
// keypoint duration back to 100 ms.
`include "timed_blink_pattern_generator_core_macros.svh"

module timed_blink_pattern_generator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tbpg_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tbpg_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import tbpg_pkg::*;

    logic        stg_valid_reg;
    req_t        stg_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    logic [15:0] keypoint_reg;

    logic        running_reg, running_next;
    logic        blinking_reg, blinking_next;
    logic        level_reg, level_next;
    logic [31:0] end_time_reg, end_time_next;
    logic [31:0] toggle_time_reg, toggle_time_next;
    logic [7:0]  on_period_reg, on_period_next;
    logic [7:0]  off_period_reg, off_period_next;

    logic advance;
    logic load;

    function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

    // Response register frees up when empty or being drained.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign load      = stg_valid_reg && advance;
    assign req_ready = !stg_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        running_next     = running_reg;
        blinking_next    = blinking_reg;
        level_next       = level_reg;
        end_time_next    = end_time_reg;
        toggle_time_next = toggle_time_reg;
        on_period_next   = on_period_reg;
        off_period_next  = off_period_reg;
        if (load)
        begin
            unique case (stg_reg.func)
                FUNC_TICK:
                begin
                    if (running_reg)
                    begin
                        if (reached(stg_reg.now_ms, end_time_reg))
                        begin
                            running_next  = 1'b0;
                            blinking_next = 1'b0;
                            level_next    = 1'b0;
                        end
                        else if (blinking_reg && reached(stg_reg.now_ms, toggle_time_reg))
                        begin
                            level_next       = !level_reg;
                            // level was off, now on: wait on_period
                            toggle_time_next = stg_reg.now_ms + {24'd0,
                                (level_reg ? off_period_reg : on_period_reg)};
                        end
                    end
                end
                FUNC_START:
                begin
                    unique case (stg_reg.pattern) inside
                        PAT_KEYPOINT, PAT_STOP, PAT_SHORT:
                        begin
                            running_next  = 1'b1;
                            blinking_next = 1'b0;
                            level_next    = 1'b1;
                            if (stg_reg.pattern == PAT_KEYPOINT)
                                end_time_next = stg_reg.now_ms + {16'd0, keypoint_reg};
                            else if (stg_reg.pattern == PAT_STOP)
                                end_time_next = stg_reg.now_ms + STOP_MS;
                            else
                                end_time_next = stg_reg.now_ms + SHORT_MS;
                        end
                        PAT_COMPLETE:
                        begin
                            running_next     = 1'b1;
                            blinking_next    = 1'b1;
                            level_next       = 1'b1;
                            on_period_next   = COMPLETE_ON_MS;
                            off_period_next  = COMPLETE_OFF_MS;
                            end_time_next    = stg_reg.now_ms + COMPLETE_TOTAL_MS;
                            toggle_time_next = stg_reg.now_ms + {24'd0, COMPLETE_ON_MS};
                        end
                        PAT_ERROR:
                        begin
                            running_next     = 1'b1;
                            blinking_next    = 1'b1;
                            level_next       = 1'b1;
                            on_period_next   = ERROR_ON_MS;
                            off_period_next  = ERROR_OFF_MS;
                            end_time_next    = stg_reg.now_ms + ERROR_TOTAL_MS;
                            toggle_time_next = stg_reg.now_ms + {24'd0, ERROR_ON_MS};
                        end
                        PAT_AIM_OK:
                        begin
                            running_next     = 1'b1;
                            blinking_next    = 1'b1;
                            level_next       = 1'b1;
                            on_period_next   = AIM_OK_ON_MS;
                            off_period_next  = AIM_OK_OFF_MS;
                            end_time_next    = stg_reg.now_ms + AIM_OK_TOTAL_MS;
                            toggle_time_next = stg_reg.now_ms + {24'd0, AIM_OK_ON_MS};
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_CANCEL:
                begin
                    running_next  = 1'b0;
                    blinking_next = 1'b0;
                    level_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            keypoint_reg  <= KEYPOINT_RESET_MS;
            running_reg   <= 1'b0;
            blinking_reg  <= 1'b0;
            level_reg     <= 1'b0;
        end
        else
        begin
            if (req_ready)
                stg_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= stg_valid_reg;
            if (cfg_valid && cfg_ready)
                keypoint_reg <= cfg_data;
            running_reg  <= running_next;
            blinking_reg <= blinking_next;
            level_reg    <= level_next;
        end
    end

    // Times and periods are only read after a start has written them.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            stg_reg <= req;
        if (load)
        begin
            rsp_reg.signal_on <= level_next;
            rsp_reg.active    <= running_next;
        end
        end_time_reg    <= end_time_next;
        toggle_time_reg <= toggle_time_next;
        on_period_reg   <= on_period_next;
        off_period_reg  <= off_period_next;
    end

    `TBPG_ASSERT_ALWAYS(a_level_needs_run, (rst_n && level_reg) |-> running_reg, "on while idle")
    `TBPG_ASSERT(a_blink_needs_run, blinking_reg |-> running_reg, "blinking while idle")
    `TBPG_ASSERT(a_rsp_matches_state, load |=> (rsp_reg == {level_reg, running_reg}), "bad rsp")
    `TBPG_ASSERT(a_cancel_idles, (load && stg_reg.func == FUNC_CANCEL) |=> !running_reg, "no idle")

endmodule
